/* rtl/mwpid_pkg.sv */
package mwpid_pkg;

  localparam int RPM_FRAC  = 8;
  localparam int GAIN_FRAC = 12;
  localparam int OUT_SHIFT = RPM_FRAC + GAIN_FRAC;
  localparam int MEAS_DN   = GAIN_FRAC - RPM_FRAC;

  localparam logic signed [29:0] ERR_MAX = 30'sd134217727;
  localparam logic signed [29:0] ERR_MIN = -30'sd134217728;
  localparam logic [19:0] SUM_CAP = 20'd524287;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^23.
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_INT_LIMIT = 3'd3;
  localparam logic [2:0] REG_OUT_LIMIT = 3'd4;
  localparam logic [2:0] REG_PERIOD    = 3'd5;
  localparam logic [2:0] REG_TIMEOUT   = 3'd6;
  localparam logic [2:0] REG_RPM_SCALE = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAS,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_LIMIT,
    ST_CMP_MUL,
    ST_CMP_DIV,
    ST_STORE,
    ST_FINISH
  } state_t;

endpackage

/* rtl/mecanum_wheel_pid_speed_loop.sv */
// An accepted request steps each of the four wheels in turn through ST_MEAS to
// ST_STORE, then loads the output register from ST_FINISH.
// No new request is taken until the sequencer is back in ST_IDLE; a held
// result keeps the sequencer waiting until out_stall drops. A single shared
// multiplier runs every product of all four wheels in sequence.
// Reset (synchronous, active high) restores the register defaults and clears the
// integral and previous error of every wheel.
module mecanum_wheel_pid_speed_loop
  import mwpid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] velocity_x,
  input  logic signed [15:0] velocity_y,
  input  logic signed [15:0] turn_rate,
  input  logic signed [15:0] count_left_front,
  input  logic signed [15:0] count_right_front,
  input  logic signed [15:0] count_left_rear,
  input  logic signed [15:0] count_right_rear,
  input  logic [15:0]        command_age_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  duty_left_front,
  output logic signed [7:0]  duty_right_front,
  output logic signed [7:0]  duty_left_rear,
  output logic signed [7:0]  duty_right_rear,
  output logic [16:0]        lf_compare_a,
  output logic [16:0]        lf_compare_b,
  output logic [16:0]        lr_compare_a,
  output logic [16:0]        lr_compare_b,
  output logic [16:0]        rf_compare_a,
  output logic [16:0]        rf_compare_b,
  output logic [16:0]        rr_compare_a,
  output logic [16:0]        rr_compare_b
);

  logic [15:0] gain_p, gain_i, gain_d, pwm_period, command_timeout_ms, rpm_scale;
  logic [9:0]  integral_limit;
  logic [6:0]  output_limit;

  state_t state, state_next;
  logic [1:0] wheel;

  logic signed [17:0] target [4];
  logic signed [15:0] count [4];
  logic signed [19:0] error_sum [4];
  logic signed [27:0] previous_error [4];
  logic signed [7:0]  duty_r [4];
  logic [16:0]        cmp_r [4];

  logic signed [27:0] err_r;
  logic signed [19:0] sum_r;
  logic signed [28:0] diff_r;
  logic signed [55:0] prod;
  logic signed [47:0] acc;
  logic [6:0]         mag_r;
  logic               neg_r;

  logic in_accept, cfg_write;
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p             <= 16'd4915;
      gain_i             <= 16'd410;
      gain_d             <= 16'd82;
      integral_limit     <= 10'd50;
      output_limit       <= 7'd100;
      pwm_period         <= 16'd65535;
      command_timeout_ms <= 16'd500;
      rpm_scale          <= 16'd9309;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_GAIN_P:    gain_p             <= pwdata[15:0];
        REG_GAIN_I:    gain_i             <= pwdata[15:0];
        REG_GAIN_D:    gain_d             <= pwdata[15:0];
        REG_INT_LIMIT: integral_limit     <= pwdata[9:0];
        REG_OUT_LIMIT: output_limit       <= pwdata[6:0];
        REG_PERIOD:    pwm_period         <= pwdata[15:0];
        REG_TIMEOUT:   command_timeout_ms <= pwdata[15:0];
        REG_RPM_SCALE: rpm_scale          <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GAIN_P:    prdata = {16'd0, gain_p};
      REG_GAIN_I:    prdata = {16'd0, gain_i};
      REG_GAIN_D:    prdata = {16'd0, gain_d};
      REG_INT_LIMIT: prdata = {22'd0, integral_limit};
      REG_OUT_LIMIT: prdata = {25'd0, output_limit};
      REG_PERIOD:    prdata = {16'd0, pwm_period};
      REG_TIMEOUT:   prdata = {16'd0, command_timeout_ms};
      REG_RPM_SCALE: prdata = {16'd0, rpm_scale};
      default:       prdata = 32'd0;
    endcase
  end

  // Wheel targets, with a stale command taken as zero.
  logic               stale;
  logic signed [17:0] vx, vy, vw;
  assign stale = command_age_ms > command_timeout_ms;
  assign vx = stale ? 18'sd0 : 18'(velocity_x);
  assign vy = stale ? 18'sd0 : 18'(velocity_y);
  assign vw = stale ? 18'sd0 : 18'(turn_rate);

  // Shared multiplier: signed 30-bit operand by unsigned 25-bit operand.
  logic signed [29:0] mul_a;
  logic [24:0]        mul_b;
  logic signed [55:0] mul_p;
  logic [16:0]        period_full;
  assign period_full = {1'b0, pwm_period} + 17'd1;

  always_comb begin
    case (state)
      ST_MEAS: begin
        mul_a = 30'(count[wheel]);
        mul_b = {9'd0, rpm_scale};
      end
      ST_MUL_P: begin
        mul_a = 30'(err_r);
        mul_b = {9'd0, gain_p};
      end
      ST_MUL_I: begin
        mul_a = 30'(sum_r);
        mul_b = {9'd0, gain_i};
      end
      ST_MUL_D: begin
        mul_a = 30'(diff_r);
        mul_b = {9'd0, gain_d};
      end
      ST_CMP_MUL: begin
        mul_a = {23'd0, mag_r};
        mul_b = {8'd0, period_full};
      end
      ST_CMP_DIV: begin
        mul_a = {7'd0, prod[22:0]};
        mul_b = {1'b0, RECIP_100};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // Error and clamped integral of the current wheel, from the registered product.
  logic signed [27:0] meas;
  logic signed [29:0] err_wide, sum_wide;
  logic signed [27:0] err_c;
  logic signed [19:0] sum_c;
  logic [19:0]        ilim;
  logic [19:0]        ilim_raw;
  assign meas     = prod[MEAS_DN +: 28];
  assign err_wide = (30'(target[wheel]) <<< RPM_FRAC) - 30'(meas);
  assign err_c    = (err_wide > ERR_MAX) ? 28'(ERR_MAX) :
                    (err_wide < ERR_MIN) ? 28'(ERR_MIN) : err_wide[27:0];
  assign ilim_raw = 20'(integral_limit) << RPM_FRAC;
  assign ilim     = (ilim_raw > SUM_CAP) ? SUM_CAP : ilim_raw;
  assign sum_wide = 30'(error_sum[wheel]) + 30'(err_c);
  assign sum_c    = (sum_wide > $signed({10'd0, ilim})) ? $signed(ilim) :
                    (sum_wide < -$signed({10'd0, ilim})) ? -$signed(ilim) :
                    sum_wide[19:0];

  // Output clamp.
  logic [6:0]         ocap;
  logic signed [47:0] olim, o_c, o_abs;
  assign ocap  = (output_limit > 7'd100) ? 7'd100 : output_limit;
  assign olim  = $signed({41'd0, ocap}) <<< OUT_SHIFT;
  assign o_c   = (acc > olim) ? olim : (acc < -olim) ? -olim : acc;
  assign o_abs = o_c[47] ? -o_c : o_c;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_accept) state_next = ST_MEAS;
      ST_MEAS:    state_next = ST_ERR;
      ST_ERR:     state_next = ST_MUL_P;
      ST_MUL_P:   state_next = ST_MUL_I;
      ST_MUL_I:   state_next = ST_MUL_D;
      ST_MUL_D:   state_next = ST_ACC;
      ST_ACC:     state_next = ST_LIMIT;
      ST_LIMIT:   state_next = ST_CMP_MUL;
      ST_CMP_MUL: state_next = ST_CMP_DIV;
      ST_CMP_DIV: state_next = ST_STORE;
      ST_STORE:   state_next = (wheel == 2'd3) ? ST_FINISH : ST_MEAS;
      ST_FINISH:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        error_sum[i]      <= '0;
        previous_error[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          wheel <= 2'd0;
          if (in_accept) begin
            target[0] <= vx + vy - vw;
            target[1] <= vx - vy + vw;
            target[2] <= vx - vy - vw;
            target[3] <= vx + vy + vw;
            count[0]  <= count_left_front;
            count[1]  <= count_right_front;
            count[2]  <= count_left_rear;
            count[3]  <= count_right_rear;
          end
        end
        ST_ERR: begin
          err_r                 <= err_c;
          sum_r                 <= sum_c;
          diff_r                <= 29'(err_c) - 29'(previous_error[wheel]);
          error_sum[wheel]      <= sum_c;
          previous_error[wheel] <= err_c;
        end
        ST_MUL_I: acc <= prod[47:0];
        ST_MUL_D: acc <= acc + prod[47:0];
        ST_ACC:   acc <= acc + prod[47:0];
        ST_LIMIT: begin
          mag_r <= o_abs[OUT_SHIFT +: 7];
          neg_r <= o_c[47];
        end
        ST_STORE: begin
          duty_r[wheel] <= neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
          cmp_r[wheel]  <= prod[RECIP_SHIFT +: 17];
          wheel         <= wheel + 2'd1;
        end
        default: ;
      endcase
      if (state != ST_IDLE && state != ST_FINISH) prod <= mul_p;
    end
  end

  // Output register; the right-hand wheels drive their bridge reversed.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && (!out_valid || !out_stall)) begin
      out_valid        <= 1'b1;
      duty_left_front  <= duty_r[0];
      duty_right_front <= duty_r[1];
      duty_left_rear   <= duty_r[2];
      duty_right_rear  <= duty_r[3];
      lf_compare_a     <= (duty_r[0] > 0) ? cmp_r[0] : 17'd0;
      lf_compare_b     <= (duty_r[0] < 0) ? cmp_r[0] : 17'd0;
      rf_compare_a     <= (duty_r[1] < 0) ? cmp_r[1] : 17'd0;
      rf_compare_b     <= (duty_r[1] > 0) ? cmp_r[1] : 17'd0;
      lr_compare_a     <= (duty_r[2] > 0) ? cmp_r[2] : 17'd0;
      lr_compare_b     <= (duty_r[2] < 0) ? cmp_r[2] : 17'd0;
      rr_compare_a     <= (duty_r[3] < 0) ? cmp_r[3] : 17'd0;
      rr_compare_b     <= (duty_r[3] > 0) ? cmp_r[3] : 17'd0;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("request accepted while the sequencer did not start");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_left_front <= 8'sd100 && duty_left_front >= -8'sd100 &&
                   duty_right_rear <= 8'sd100 && duty_right_rear >= -8'sd100))
    else $error("duty outside plus or minus one hundred");

  a_zero_duty_idle_bridge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && duty_left_front == 8'sd0) |-> (lf_compare_a == 17'd0 && lf_compare_b == 17'd0))
    else $error("bridge driven at zero duty");

endmodule
